FILE: hw/rtl/hfd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hfd_pkg - shared types and constants of the Huffman bit-serial decoder
// Field widths, input mode codes, the command word that travels through the
// command queue and the raw result word that leaves the bit engine.
// ============================================================================
package hfd_pkg;

    // Field widths of the input and result words.
    localparam int MODE_W     = 2;
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int CODE_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NBITS_W    = 4;
    localparam int BIT_IDX_W  = 3;

    // Every symbol that an 8-bit result can name.
    localparam int SYMBOL_SPACE = 2 ** SYM_W;

    // Command queue between the front and the bit engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Symbol encoder: groups of 16 match bits.
    localparam int GROUP_W    = 16;
    localparam int GRP_IDX_W  = 4;
    localparam int GRPNUM_W   = SYM_W - GRP_IDX_W;
    localparam int NUM_GROUPS = SYMBOL_SPACE / GROUP_W;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Full-byte bit count.
    localparam logic [NBITS_W-1:0] BYTE_BITS = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DECODE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [SYM_W-1:0]   symbol;
        logic [LEN_W-1:0]   length;
        logic [CODE_W-1:0]  code;
        logic [BYTE_W-1:0]  data;
        logic [NBITS_W-1:0] nbits;
    } cmd_t;

    typedef struct packed {
        logic                    valid;
        logic                    err;
        logic                    last;
        logic [SYMBOL_SPACE-1:0] vec;
    } push_t;

endpackage

FILE: hw/rtl/huffman_bit_serial_decoder_top.sv
`timescale 1ns / 1ps
// ============================================================================
// huffman_bit_serial_decoder_top - bit-serial Huffman decoder, LSB first
// Loads a per-symbol code table, clears it, and decodes data bytes one code
// bit per cycle when not stalled, emitting one result word per completed code.
// ============================================================================
// Each input word is a load (write one table entry), a decode (a data byte
// whose lowest valid_bits bits are consumed least significant first) or a
// clear (empty the table and the partial code). Input words pass through a
// four-deep command queue, so the input side keeps accepting while the engine
// works, until the queue is full. The engine takes one queued command in each
// dispatch state: a load or a clear is done there, and a decode enters the
// bit loop, which takes its valid bits one by one and returns to dispatch
// after the last one or after an overlong code. The bit loop appends one bit
// to the accumulator and compares it against every table entry in the same
// cycle; the lowest matching symbol wins. Thirty-two bits without a match
// (or MAX_CODE_LEN) give an error word with symbol zero and discard the rest
// of that byte. The newest result of a byte waits in the engine until the
// byte ends, so that its last_of_byte flag is known, and then passes from the
// pending register through a two-stage symbol encoder whose second register
// is the output register. A stall on the output freezes the engine and the
// encoder until the word is taken; the queue still fills meanwhile. Mode 3
// and decodes with no valid bits are accepted and dropped. No clearing pass
// follows reset: the table's valid marks reset at once.
// ============================================================================
module huffman_bit_serial_decoder_top
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [hfd_pkg::MODE_W-1:0]    mode,
    input  logic [hfd_pkg::SYM_W-1:0]     entry_symbol,
    input  logic [hfd_pkg::LEN_W-1:0]     entry_length,
    input  logic [hfd_pkg::CODE_W-1:0]    entry_code,
    input  logic [hfd_pkg::BYTE_W-1:0]    data_byte,
    input  logic [hfd_pkg::NBITS_W-1:0]   valid_bits,
    // Result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [hfd_pkg::SYM_W-1:0]     decoded_symbol,
    output logic                          overlong_error,
    output logic                          last_of_byte
);

    hfd_pkg::cmd_t  head;
    logic           head_valid;
    logic           pop;
    logic           advance;
    hfd_pkg::push_t push;

    // Front end: classifies input words and queues the useful ones.
    hfd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .entry_symbol (entry_symbol),
        .entry_length (entry_length),
        .entry_code   (entry_code),
        .data_byte    (data_byte),
        .valid_bits   (valid_bits),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop)
    );

    // Back end: code table and the bit loop.
    hfd_engine
    #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .advance    (advance),
        .push       (push)
    );

    // Symbol encoder and output register; advance is its ability to move on.
    hfd_result u_result
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .advance        (advance),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .decoded_symbol (decoded_symbol),
        .overlong_error (overlong_error),
        .last_of_byte   (last_of_byte)
    );

endmodule

FILE: hw/rtl/hfd_front.sv
`timescale 1ns / 1ps
// ============================================================================
// hfd_front - input front end and command queue
// Takes input words, sorts them into load, decode and clear commands, drops
// those that do nothing, and holds the rest in a short queue for the engine.
// ============================================================================
module hfd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [hfd_pkg::MODE_W-1:0]    mode,
    input  logic [hfd_pkg::SYM_W-1:0]     entry_symbol,
    input  logic [hfd_pkg::LEN_W-1:0]     entry_length,
    input  logic [hfd_pkg::CODE_W-1:0]    entry_code,
    input  logic [hfd_pkg::BYTE_W-1:0]    data_byte,
    input  logic [hfd_pkg::NBITS_W-1:0]   valid_bits,
    output hfd_pkg::cmd_t                 head,
    output logic                          head_valid,
    input  logic                          pop
);

    hfd_pkg::cmd_t                 queue_mem [hfd_pkg::QUEUE_DEPTH];
    logic [hfd_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [hfd_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [hfd_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [hfd_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [hfd_pkg::QPTR_W:0]      count_reg;
    logic [hfd_pkg::QPTR_W:0]      count_next;
    hfd_pkg::cmd_t                 cmd;
    logic                          keep;
    logic                          push_q;
    logic                          pop_q;

    // Classification of the incoming word.
    always_comb
    begin
        cmd.op     = hfd_pkg::OP_LOAD;
        cmd.symbol = entry_symbol;
        cmd.length = entry_length;
        cmd.code   = entry_code;
        cmd.data   = data_byte;
        cmd.nbits  = (valid_bits > hfd_pkg::BYTE_BITS) ? hfd_pkg::BYTE_BITS : valid_bits;
        keep       = 1'b0;
        unique case (mode)
            hfd_pkg::MODE_LOAD:
            begin
                cmd.op = hfd_pkg::OP_LOAD;
                keep   = 1'b1;
            end
            hfd_pkg::MODE_DECODE:
            begin
                cmd.op = hfd_pkg::OP_DECODE;
                keep   = (valid_bits != '0);
            end
            hfd_pkg::MODE_CLEAR:
            begin
                cmd.op = hfd_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign item_stall = (count_reg == (hfd_pkg::QPTR_W + 1)'(hfd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = queue_mem[rd_ptr_reg];
    assign push_q     = item_valid && !item_stall && keep;
    assign pop_q      = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push_q ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_q ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_q && !pop_q)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_q && !push_q)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            queue_mem[wr_ptr_reg] <= cmd;
        end
    end

endmodule

FILE: hw/rtl/hfd_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// hfd_engine - code table and bit-serial decode engine
// Holds the code table, executes queued commands and steps one code bit per
// cycle, unless stalled, against every table entry at once. The newest result
// waits in a pending register until it is known whether it closes its byte.
// ============================================================================
module hfd_engine
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  hfd_pkg::cmd_t  head,
    input  logic           head_valid,
    output logic           pop,
    input  logic           advance,
    output hfd_pkg::push_t push
);

    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int SIDX_W = $clog2(NUM_SYMBOLS);
    localparam int CMP_W  = (MAX_CODE_LEN > hfd_pkg::CODE_W) ? MAX_CODE_LEN : hfd_pkg::CODE_W;

    typedef enum logic [1:0] {
        ST_DISPATCH = 2'b01,
        ST_BITS     = 2'b10
    } eng_state_t;

    eng_state_t                         state_reg;
    eng_state_t                         state_next;
    logic [MAX_CODE_LEN-1:0]            acc_reg;
    logic [MAX_CODE_LEN-1:0]            acc_next;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [CNT_W-1:0]                   cnt_next;
    logic [hfd_pkg::NBITS_W-1:0]        idx_reg;
    logic [hfd_pkg::NBITS_W-1:0]        idx_next;
    logic [hfd_pkg::BYTE_W-1:0]         byte_reg;
    logic [hfd_pkg::BYTE_W-1:0]         byte_next;
    logic [hfd_pkg::NBITS_W-1:0]        nbits_reg;
    logic [hfd_pkg::NBITS_W-1:0]        nbits_next;
    logic                               pend_valid_reg;
    logic                               pend_valid_next;
    logic [hfd_pkg::SYMBOL_SPACE-1:0]   pend_vec_reg;
    logic [hfd_pkg::SYMBOL_SPACE-1:0]   pend_vec_next;
    logic                               pend_err_reg;
    logic                               pend_err_next;

    logic                               tbl_valid_reg  [NUM_SYMBOLS];
    logic [hfd_pkg::LEN_W-1:0]          tbl_length_reg [NUM_SYMBOLS];
    logic [hfd_pkg::CODE_W-1:0]         tbl_code_reg   [NUM_SYMBOLS];

    logic                               bit_val;
    logic [MAX_CODE_LEN-1:0]            acc_new;
    logic [CNT_W-1:0]                   cnt_new;
    logic [NUM_SYMBOLS-1:0]             match_vec;
    logic                               any_match;
    logic                               tbl_load;
    logic                               tbl_clear;
    logic                               sym_in_range;
    logic                               pop_int;

    assign bit_val      = byte_reg[idx_reg[hfd_pkg::BIT_IDX_W-1:0]];
    assign acc_new      = acc_reg | (MAX_CODE_LEN'(bit_val) << cnt_reg);
    assign cnt_new      = cnt_reg + 1'b1;
    assign any_match    = |match_vec;
    assign sym_in_range = ((hfd_pkg::SYM_W + 1)'(head.symbol) < (hfd_pkg::SYM_W + 1)'(NUM_SYMBOLS));
    assign pop          = pop_int && advance;

    // Every entry compares itself with the accumulator after the new bit.
    always_comb
    begin
        for (int s = 0; s < NUM_SYMBOLS; s++)
        begin
            match_vec[s] = tbl_valid_reg[s]
                && (tbl_length_reg[s] == hfd_pkg::LEN_W'(cnt_new))
                && (CMP_W'(tbl_code_reg[s]) == CMP_W'(acc_new));
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        byte_next       = byte_reg;
        nbits_next      = nbits_reg;
        pend_valid_next = pend_valid_reg;
        pend_vec_next   = pend_vec_reg;
        pend_err_next   = pend_err_reg;
        push.valid      = 1'b0;
        push.err        = pend_err_reg;
        push.last       = 1'b0;
        push.vec        = pend_vec_reg;
        pop_int         = 1'b0;
        tbl_load        = 1'b0;
        tbl_clear       = 1'b0;
        unique case (state_reg)
            ST_DISPATCH:
            begin
                // The pending result is the last one of the finished byte.
                push.valid      = pend_valid_reg;
                push.last       = 1'b1;
                pend_valid_next = 1'b0;
                if (head_valid)
                begin
                    pop_int = 1'b1;
                    unique case (head.op)
                        hfd_pkg::OP_LOAD:
                        begin
                            tbl_load = 1'b1;
                        end
                        hfd_pkg::OP_CLEAR:
                        begin
                            tbl_clear = 1'b1;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                        hfd_pkg::OP_DECODE:
                        begin
                            byte_next  = head.data;
                            nbits_next = head.nbits;
                            idx_next   = '0;
                            state_next = ST_BITS;
                        end
                        default:
                        begin
                            pop_int = 1'b1;
                        end
                    endcase
                end
            end
            ST_BITS:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_next == nbits_reg)
                begin
                    state_next = ST_DISPATCH;
                end
                if (any_match)
                begin
                    push.valid      = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_vec_next   = hfd_pkg::SYMBOL_SPACE'(match_vec);
                    pend_err_next   = 1'b0;
                    acc_next        = '0;
                    cnt_next        = '0;
                end
                else if (cnt_new == CNT_W'(MAX_CODE_LEN))
                begin
                    // Overlong code: report it and drop the rest of the byte.
                    push.valid      = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_vec_next   = '0;
                    pend_err_next   = 1'b1;
                    acc_next        = '0;
                    cnt_next        = '0;
                    state_next      = ST_DISPATCH;
                end
                else
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                end
            end
            default:
            begin
                state_next = ST_DISPATCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_DISPATCH;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_SYMBOLS; s++)
            begin
                tbl_valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            if (tbl_clear)
            begin
                for (int s = 0; s < NUM_SYMBOLS; s++)
                begin
                    tbl_valid_reg[s] <= 1'b0;
                end
            end
            else if (tbl_load && sym_in_range)
            begin
                tbl_valid_reg[head.symbol[SIDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg      <= byte_next;
            nbits_reg     <= nbits_next;
            pend_vec_reg  <= pend_vec_next;
            pend_err_reg  <= pend_err_next;
            if (tbl_load && sym_in_range)
            begin
                tbl_length_reg[head.symbol[SIDX_W-1:0]] <= head.length;
                tbl_code_reg[head.symbol[SIDX_W-1:0]]   <= head.code;
            end
        end
    end

endmodule

FILE: hw/rtl/hfd_result.sv
`timescale 1ns / 1ps
// ============================================================================
// hfd_result - symbol encoder and output register
// Turns the match vector into the lowest matching symbol over two registered
// stages and presents the result word on the output channel.
// ============================================================================
module hfd_result
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hfd_pkg::push_t                push,
    output logic                          advance,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [hfd_pkg::SYM_W-1:0]     decoded_symbol,
    output logic                          overlong_error,
    output logic                          last_of_byte
);

    logic                               s1_valid_reg;
    logic [hfd_pkg::NUM_GROUPS-1:0]     s1_any_reg;
    logic [hfd_pkg::NUM_GROUPS-1:0]     s1_any_next;
    logic [hfd_pkg::GRP_IDX_W-1:0]      s1_idx_reg  [hfd_pkg::NUM_GROUPS];
    logic [hfd_pkg::GRP_IDX_W-1:0]      s1_idx_next [hfd_pkg::NUM_GROUPS];
    logic                               s1_err_reg;
    logic                               s1_last_reg;
    logic                               out_valid_reg;
    logic [hfd_pkg::SYM_W-1:0]          out_sym_reg;
    logic [hfd_pkg::SYM_W-1:0]          out_sym_next;
    logic                               out_err_reg;
    logic                               out_last_reg;
    logic [hfd_pkg::NUM_GROUPS-1:0]     grp_iso;

    assign advance        = !out_valid_reg || !result_stall;
    assign result_valid   = out_valid_reg;
    assign decoded_symbol = out_sym_reg;
    assign overlong_error = out_err_reg;
    assign last_of_byte   = out_last_reg;

    // First stage: lowest set bit inside each group of match bits.
    always_comb
    begin
        logic [hfd_pkg::GROUP_W-1:0] gv;
        logic [hfd_pkg::GROUP_W-1:0] giso;
        for (int g = 0; g < hfd_pkg::NUM_GROUPS; g++)
        begin
            gv             = push.vec[g*hfd_pkg::GROUP_W +: hfd_pkg::GROUP_W];
            giso           = gv & (~gv + hfd_pkg::GROUP_W'(1));
            s1_any_next[g] = |gv;
            s1_idx_next[g] = '0;
            for (int b = 0; b < hfd_pkg::GROUP_W; b++)
            begin
                s1_idx_next[g] = s1_idx_next[g]
                    | (giso[b] ? hfd_pkg::GRP_IDX_W'(b) : hfd_pkg::GRP_IDX_W'(0));
            end
        end
    end

    // Second stage: lowest group that holds a match.
    always_comb
    begin
        grp_iso      = s1_any_reg & (~s1_any_reg + hfd_pkg::NUM_GROUPS'(1));
        out_sym_next = '0;
        for (int g = 0; g < hfd_pkg::NUM_GROUPS; g++)
        begin
            out_sym_next = out_sym_next
                | (grp_iso[g] ? {hfd_pkg::GRPNUM_W'(g), s1_idx_reg[g]} : hfd_pkg::SYM_W'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= push.valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_any_reg   <= s1_any_next;
            s1_idx_reg   <= s1_idx_next;
            s1_err_reg   <= push.err;
            s1_last_reg  <= push.last;
            out_sym_reg  <= out_sym_next;
            out_err_reg  <= s1_err_reg;
            out_last_reg <= s1_last_reg;
        end
    end

endmodule
